// ----- rtl/jpeg_entropy_bit_reader_defines.svh -----
// Assertion macros for the JPEG entropy-coded segment bit reader.
// Included by the RTL files that carry assertions; expects clk and rst_n in scope.
`ifndef JPEG_ENTROPY_BIT_READER_DEFINES_SVH
`define JPEG_ENTROPY_BIT_READER_DEFINES_SVH

`ifndef SYNTHESIS
`define JEB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define JEB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JEB_ASSERT(lbl, prop, msg)
`define JEB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/jeb_pkg.sv -----
// Shared types and constants for the JPEG entropy-coded segment bit reader.
// No dependencies; used by every module of the block.
package jeb_pkg;

    localparam int STORE_BITS = 32;
    localparam int FILL_W     = $clog2(STORE_BITS + 1);
    localparam int AVAIL_W    = 6;
    localparam int LEN_W      = 5;
    localparam int FIELD_MAX  = 16;
    localparam int VALUE_W    = 17;
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] BYTE_MARKER = 8'hFF;
    localparam logic [7:0] BYTE_STUFF  = 8'h00;
    localparam logic [7:0] BYTE_EOI    = 8'hD9;
    localparam logic [3:0] NIBBLE_MAX  = 4'd9;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_STOPPED   = 2'd3
    } status_t;

    typedef struct packed {
        logic             mode;
        logic [7:0]       byte_in;
        logic [LEN_W-1:0] field_length;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
        logic [3:0]                restart_index;
        logic                      end_seen;
        logic [AVAIL_W-1:0]        bits_available;
    } result_t;

    // Classified item as it sits in the queue.
    typedef struct packed {
        mode_t            mode;
        logic [7:0]       data;
        logic             is_marker;
        logic             is_stuff;
        logic             is_eoi;
        logic [3:0]       nibble;
        logic             nibble_halt;
        logic [LEN_W-1:0] len;
    } cls_t;

endpackage

// ----- rtl/jeb_front.sv -----
// Front end: decodes an input beat into a classified entry for the queue.
// Depends on jeb_pkg.
module jeb_front (
    input  jeb_pkg::item_t item,
    output jeb_pkg::cls_t  cls
);

    always_comb
    begin
        cls.mode        = jeb_pkg::mode_t'(item.mode);
        cls.data        = item.byte_in;
        cls.is_marker   = (item.byte_in == jeb_pkg::BYTE_MARKER);
        cls.is_stuff    = (item.byte_in == jeb_pkg::BYTE_STUFF);
        cls.is_eoi      = (item.byte_in == jeb_pkg::BYTE_EOI);
        cls.nibble      = item.byte_in[3:0];
        cls.nibble_halt = (item.byte_in[3:0] > jeb_pkg::NIBBLE_MAX);
        // field lengths above the maximum clamp to it
        if (item.field_length > jeb_pkg::LEN_W'(jeb_pkg::FIELD_MAX))
        begin
            cls.len = jeb_pkg::LEN_W'(jeb_pkg::FIELD_MAX);
        end
        else
        begin
            cls.len = item.field_length;
        end
    end

endmodule

// ----- rtl/jeb_queue.sv -----
// Short FIFO of classified entries between the front end and the back end.
// Depends on jeb_pkg.
module jeb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jeb_pkg::cls_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output jeb_pkg::cls_t head
);

    jeb_pkg::cls_t                entry_reg [jeb_pkg::Q_DEPTH];
    logic [jeb_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [jeb_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [jeb_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == jeb_pkg::QCNT_W'(jeb_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == jeb_pkg::QPTR_W'(jeb_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == jeb_pkg::QPTR_W'(jeb_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/jeb_back.sv -----
// Back end: bit buffer, marker state and the registered result beat.
// Depends on jeb_pkg and jpeg_entropy_bit_reader_defines.svh.
`include "jpeg_entropy_bit_reader_defines.svh"

module jeb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  jeb_pkg::cls_t   q_head,
    output logic            q_pop,
    output logic            result_valid,
    input  logic            result_stall,
    output jeb_pkg::result_t result
);

    logic [jeb_pkg::STORE_BITS-1:0] store_reg, store_next;
    logic [jeb_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic                           pending_reg, pending_next;
    logic [3:0]                     restart_reg, restart_next;
    logic                           end_reg, end_next;
    logic                           stopped_reg, stopped_next;
    logic                           res_valid_reg, res_valid_next;
    jeb_pkg::result_t               res_reg;

    logic                           fire;
    logic                           do_push;
    logic                           room;
    logic [7:0]                     push_byte;
    jeb_pkg::status_t               status;
    logic signed [jeb_pkg::VALUE_W-1:0] value;
    logic [jeb_pkg::FILL_W-1:0]     len_ext;
    logic [jeb_pkg::FILL_W-1:0]     shift;
    logic [jeb_pkg::STORE_BITS-1:0] shifted;
    logic [15:0]                    fmask;
    logic [15:0]                    raw;
    logic [3:0]                     top_idx;

    assign fire  = q_valid && (!res_valid_reg || !result_stall);
    assign q_pop = fire;

    assign len_ext = jeb_pkg::FILL_W'(q_head.len);
    assign shift   = fill_reg - len_ext;
    assign shifted = store_reg >> shift;
    assign fmask   = 16'((17'd1 << q_head.len) - 17'd1);
    assign raw     = shifted[15:0] & fmask;
    assign top_idx = 4'(q_head.len - 1'b1);
    assign room    = ({1'b0, fill_reg} + (jeb_pkg::FILL_W + 1)'(8))
                     <= (jeb_pkg::FILL_W + 1)'(jeb_pkg::STORE_BITS);

    always_comb
    begin
        pending_next = pending_reg;
        restart_next = restart_reg;
        end_next     = end_reg;
        stopped_next = stopped_reg;
        store_next   = store_reg;
        fill_next    = fill_reg;
        do_push      = 1'b0;
        push_byte    = q_head.data;
        status       = jeb_pkg::ST_OK;
        value        = '0;

        if (q_head.mode == jeb_pkg::MODE_PUSH)
        begin
            priority if (stopped_reg)
            begin
                status = jeb_pkg::ST_STOPPED;
            end
            else if (pending_reg)
            begin
                pending_next = 1'b0;
                priority if (q_head.is_stuff)
                begin
                    do_push   = 1'b1;
                    push_byte = jeb_pkg::BYTE_MARKER;
                end
                else if (q_head.is_eoi)
                begin
                    end_next     = 1'b1;
                    stopped_next = 1'b1;
                end
                else
                begin
                    restart_next = q_head.nibble;
                    if (q_head.nibble_halt)
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
            else if (q_head.is_marker)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                do_push = 1'b1;
            end

            if (do_push)
            begin
                if (room)
                begin
                    store_next = {store_reg[jeb_pkg::STORE_BITS-9:0], push_byte};
                    fill_next  = fill_reg + jeb_pkg::FILL_W'(8);
                end
                else
                begin
                    status = jeb_pkg::ST_OVERFLOW;
                end
            end
        end
        else
        begin
            priority if (len_ext > fill_reg)
            begin
                status = jeb_pkg::ST_UNDERFLOW;
            end
            else if (q_head.len != '0)
            begin
                fill_next = fill_reg - len_ext;
                // negative field when the leading bit is clear
                if (raw[top_idx])
                begin
                    value = $signed({1'b0, raw});
                end
                else
                begin
                    value = $signed({1'b0, raw}) - $signed({1'b0, fmask});
                end
            end
        end
    end

    assign res_valid_next = fire || (res_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= '0;
            fill_reg      <= '0;
            pending_reg   <= 1'b0;
            restart_reg   <= '0;
            end_reg       <= 1'b0;
            stopped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                store_reg   <= store_next;
                fill_reg    <= fill_next;
                pending_reg <= pending_next;
                restart_reg <= restart_next;
                end_reg     <= end_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg.value          <= value;
            res_reg.status         <= status;
            res_reg.restart_index  <= restart_next;
            res_reg.end_seen       <= end_next;
            res_reg.bits_available <= jeb_pkg::AVAIL_W'(fill_next);
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `JEB_ASSERT(a_fill_bound, fill_reg <= jeb_pkg::FILL_W'(jeb_pkg::STORE_BITS), "fill above store size")
    `JEB_ASSERT(a_end_stops, !end_reg || stopped_reg, "end seen without stop")
    `JEB_ASSERT_NEXT(a_stop_sticky, stopped_reg, stopped_reg, "stop flag cleared")
    `JEB_ASSERT_NEXT(a_ovf_keeps_fill, fire && do_push && !room, fill_reg == $past(fill_reg), "dropped byte changed fill")

endmodule

// ----- rtl/jpeg_entropy_bit_reader.sv -----
// JPEG entropy-coded segment bit reader: byte unstuffing, marker handling, field reads.
// Top level; depends on jeb_pkg, jeb_front, jeb_queue and jeb_back.
//
// Use: each input beat (item) either pushes one raw segment byte (mode 0) or reads
// field_length bits, MSB first, with JPEG sign extension (mode 1). Every input beat
// produces exactly one result beat, in order.
// Channels: item/result with valid and stall; a beat moves when valid is high and
// stall is low.
// An accepted beat passes through the queue, then the back end and its output register.
// Throughput: one beat per cycle while result_stall is low; the bit buffer update is combinational.
// A two-entry queue sits between the classifying front end and the back end,
// and the result is held in an output register.
// When result_stall is high the output register holds its beat; the queue fills and
// item_stall rises once it holds two entries.
// Reset (rst_n low) empties the queue and output, clears the bit buffer, the marker,
// restart and end state; the block is ready on the first cycle after reset.
module jpeg_entropy_bit_reader (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  jeb_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output jeb_pkg::result_t result
);

    jeb_pkg::cls_t cls;
    jeb_pkg::cls_t q_head;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    assign item_stall = q_full;

    jeb_front u_front (
        .item (item),
        .cls  (cls)
    );

    jeb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_valid && !q_full),
        .push_data (cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    jeb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- tb/jeb_reading_checker.sv -----
// Scoreboard for the JPEG segment bit reader: predicts one reading per item beat
// and compares it field by field with the result channel. Depends on jeb_pkg.
module jeb_reading_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  jeb_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  jeb_pkg::result_t result,
    output int               mismatches,
    output int               awaited,
    output int               compared,
    output logic [3:0]       status_hit
);

    logic [jeb_pkg::STORE_BITS-1:0] bits_buf;
    int unsigned                    bits_held;
    logic                           ff_seen;
    logic [3:0]                     restart_nib;
    logic                           eoi_met;
    logic                           halted;
    jeb_pkg::result_t               awaited_readings[$];

    function automatic jeb_pkg::status_t store_byte(logic [7:0] data);
        if (bits_held + 8 > jeb_pkg::STORE_BITS)
            return jeb_pkg::ST_OVERFLOW;
        bits_buf  = (bits_buf << 8) | data;
        bits_held = bits_held + 8;
        return jeb_pkg::ST_OK;
    endfunction

    function automatic jeb_pkg::result_t step_segment(jeb_pkg::item_t beat);
        jeb_pkg::result_t r;
        jeb_pkg::status_t st;
        int unsigned      len;
        int unsigned      fmask;
        int unsigned      raw;
        int               v;
        st = jeb_pkg::ST_OK;
        v  = 0;
        if (beat.mode == jeb_pkg::MODE_PUSH)
        begin
            if (halted)
                st = jeb_pkg::ST_STOPPED;
            else if (ff_seen)
            begin
                ff_seen = 1'b0;
                if (beat.byte_in == jeb_pkg::BYTE_STUFF)
                    st = store_byte(jeb_pkg::BYTE_MARKER);
                else if (beat.byte_in == jeb_pkg::BYTE_EOI)
                begin
                    eoi_met = 1'b1;
                    halted  = 1'b1;
                end
                else
                begin
                    restart_nib = beat.byte_in[3:0];
                    if (restart_nib > jeb_pkg::NIBBLE_MAX)
                        halted = 1'b1;
                end
            end
            else if (beat.byte_in == jeb_pkg::BYTE_MARKER)
                ff_seen = 1'b1;
            else
                st = store_byte(beat.byte_in);
        end
        else
        begin
            len = (beat.field_length > jeb_pkg::FIELD_MAX) ? jeb_pkg::FIELD_MAX
                                                           : beat.field_length;
            if (len > bits_held)
                st = jeb_pkg::ST_UNDERFLOW;
            else if (len != 0)
            begin
                fmask     = (32'd1 << len) - 1;
                raw       = (bits_buf >> (bits_held - len)) & fmask;
                bits_held = bits_held - len;
                v         = raw;
                if (((raw >> (len - 1)) & 1) == 0)
                    v = v - int'(fmask);
            end
        end
        r.value          = v[jeb_pkg::VALUE_W-1:0];
        r.status         = st;
        r.restart_index  = restart_nib;
        r.end_seen       = eoi_met;
        r.bits_available = bits_held[jeb_pkg::AVAIL_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        jeb_pkg::result_t want;
        if (!rst_n)
        begin
            bits_buf    = '0;
            bits_held   = 0;
            ff_seen     = 1'b0;
            restart_nib = '0;
            eoi_met     = 1'b0;
            halted      = 1'b0;
            awaited_readings.delete();
            mismatches  = 0;
            compared    = 0;
            awaited     = 0;
            status_hit  = '0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_readings.size() == 0)
                begin
                    $error("result beat with no reading awaited");
                    mismatches++;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    compared++;
                    status_hit[result.status] = 1'b1;
                    if (result.value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, result.value);
                        mismatches++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        mismatches++;
                    end
                    if (result.restart_index !== want.restart_index)
                    begin
                        $error("restart_index: expected %0d, got %0d",
                               want.restart_index, result.restart_index);
                        mismatches++;
                    end
                    if (result.end_seen !== want.end_seen)
                    begin
                        $error("end_seen: expected %0d, got %0d",
                               want.end_seen, result.end_seen);
                        mismatches++;
                    end
                    if (result.bits_available !== want.bits_available)
                    begin
                        $error("bits_available: expected %0d, got %0d",
                               want.bits_available, result.bits_available);
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
                awaited_readings.push_back(step_segment(item));
            awaited = awaited_readings.size();
        end
    end

endmodule

// ----- tb/tb_jpeg_entropy_bit_reader.sv -----
// Top of the JPEG segment bit reader bench: clock, reset, item stimulus and receiver stalls.
// Depends on jeb_pkg, jpeg_entropy_bit_reader and jeb_reading_checker.
module tb_jpeg_entropy_bit_reader;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    jeb_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    jeb_pkg::result_t result;

    int         mismatches;
    int         awaited;
    int         compared;
    logic [3:0] status_hit;

    logic calm          = 1'b0;
    logic marker_open   = 1'b0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   offered       = 0;
    int   stop_kind     = 0;

    always #5 clk = ~clk;

    jpeg_entropy_bit_reader dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    jeb_reading_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .compared     (compared),
        .status_hit   (status_hit)
    );

    initial
    begin
        #5_000_000;
        $display("jpeg_entropy_bit_reader test failed");
        $finish;
    end

    // receiver: random stall bursts, plus long hold-offs on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                result_stall <= 1'b1;
                repeat (120) @(posedge clk);
                result_stall <= 1'b0;
                holds_served++;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic offer(input logic mode, input logic [7:0] data, input logic [4:0] len);
        jeb_pkg::item_t beat;
        beat.mode         = mode;
        beat.byte_in      = data;
        beat.field_length = len;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        offered++;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic push_byte(input logic [7:0] data);
        offer(jeb_pkg::MODE_PUSH, data, 5'($urandom_range(0, 31)));
    endtask

    task automatic read_field(input logic [4:0] len);
        offer(jeb_pkg::MODE_READ, 8'($urandom_range(0, 255)), len);
    endtask

    // well-formed segment traffic: a marker byte is followed by stuffing or a
    // restart-style marker that keeps the reader running
    task automatic random_item();
        int         pick;
        logic [7:0] data;
        pick = $urandom_range(0, 99);
        if (pick < 48)
        begin
            if (marker_open)
            begin
                data = (pick < 30) ? jeb_pkg::BYTE_STUFF
                                   : {4'($urandom_range(0, 15)), 4'($urandom_range(0, 9))};
                if (data == jeb_pkg::BYTE_EOI)
                    data = jeb_pkg::BYTE_STUFF;
                marker_open = 1'b0;
            end
            else
            begin
                data = (pick < 6) ? jeb_pkg::BYTE_MARKER : 8'($urandom_range(0, 255));
                if (data == jeb_pkg::BYTE_MARKER)
                    marker_open = 1'b1;
            end
            push_byte(data);
        end
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                read_field(5'd0);
            else if (pick == 1)
                read_field(5'($urandom_range(17, 31)));
            else
                read_field(5'($urandom_range(1, 16)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty buffer, fill to the top, overflow, stuffed byte while full
        read_field(5'd0);
        read_field(5'd1);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'hFE);
        push_byte(8'h55);
        push_byte(jeb_pkg::BYTE_MARKER);
        push_byte(jeb_pkg::BYTE_STUFF);
        // negative and positive 16-bit fields
        read_field(5'd16);
        read_field(5'd16);
        // stuffed 0xFF becomes data
        push_byte(jeb_pkg::BYTE_MARKER);
        push_byte(jeb_pkg::BYTE_STUFF);
        read_field(5'd8);
        // long field clamps to 16 and underflows
        push_byte(8'h00);
        read_field(5'd31);
        read_field(5'd8);
        // restart marker with a read in between marker and nibble
        push_byte(jeb_pkg::BYTE_MARKER);
        read_field(5'd0);
        push_byte(8'hD3);
        push_byte(8'h81);
        read_field(5'd20);
        read_field(5'd3);
        read_field(5'd5);
        push_byte(8'h01);

        for (int i = 0; i < 1150; i++)
        begin
            if (i == 300 || i == 800)
                hold_requests++;
            random_item();
        end

        calm = 1'b1;
        for (int i = 0; i < 130; i++)
            random_item();

        // stop the reader one way or another, then keep going past it
        stop_kind = $urandom_range(0, 2);
        if (!marker_open)
            push_byte(jeb_pkg::BYTE_MARKER);
        marker_open = 1'b0;
        if (stop_kind == 0)
            push_byte(jeb_pkg::BYTE_EOI);
        else if (stop_kind == 1)
            push_byte({4'($urandom_range(0, 15)), 4'($urandom_range(10, 15))});
        else
            push_byte(jeb_pkg::BYTE_MARKER);
        for (int i = 0; i < 40; i++)
            random_item();

        item_valid <= 1'b0;
        for (int n = 0; n < 2000 && awaited != 0; n++)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (awaited != 0)
            $error("%0d readings never arrived", awaited);
        $display("%0d item beats offered, %0d result beats compared", offered, compared);
        $display("status codes seen (one bit per code): %b, stop path %0d", status_hit, stop_kind);
        if (mismatches == 0 && awaited == 0)
            $display("jpeg_entropy_bit_reader test passed");
        else
            $display("jpeg_entropy_bit_reader test failed");
        $finish;
    end

endmodule
